[src/bbpc_pkg.sv]
// ----------------------------------------------------------------------------
// bbpc_pkg
// shared types, constants and the saturating scale function for the box
// boundary clamp
// ----------------------------------------------------------------------------
package bbpc_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FACT_W        = 18;
  localparam int unsigned AXES          = 3;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned SFACT_W       = FACT_W + 2;
  localparam int unsigned PROD_W        = DATA_W + SFACT_W;

  typedef logic signed [DATA_W-1:0] q_t;
  typedef logic [FACT_W-1:0]        fac_t;
  typedef logic [AXES-1:0]          hits_t;

  localparam q_t   BOX_MIN_RST  = 32'sd0;
  localparam q_t   BOX_MAX_RST  = 32'sd65536;
  localparam fac_t NORM_FAC_RST = 18'd0;
  localparam fac_t TAN_FAC_RST  = 18'd65536;
  localparam q_t   Q_MAX        = 32'sh7fffffff;
  localparam q_t   Q_MIN        = 32'sh80000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_MIN_X    = 3'd0,
    CFG_BOX_MIN_Y    = 3'd1,
    CFG_BOX_MIN_Z    = 3'd2,
    CFG_BOX_MAX_X    = 3'd3,
    CFG_BOX_MAX_Y    = 3'd4,
    CFG_BOX_MAX_Z    = 3'd5,
    CFG_NORMAL_FACT  = 3'd6,
    CFG_TANGENT_FACT = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SC_NONE    = 2'd0,
    SC_NORMAL  = 2'd1,
    SC_TANGENT = 2'd2
  } scale_e;

  typedef struct packed {
    q_t [AXES-1:0] pos;
    q_t [AXES-1:0] vel;
    hits_t         hits;
  } particle_t;

  typedef struct packed {
    q_t [AXES-1:0] lo;
    q_t [AXES-1:0] hi;
    fac_t          nf;
    fac_t          tf;
  } box_cfg_t;

  // v * f, negated for restitution, floor shift, saturate to 32 bits
  function automatic q_t scale_sat(input q_t v, input fac_t f, input logic neg,
                                   input int unsigned frac);
    logic signed [SFACT_W-1:0] sf;
    logic signed [PROD_W-1:0]  p;
    logic signed [PROD_W-1:0]  sh;
    q_t                        r;
    sf = $signed({2'b00, f});
    if (neg) begin
      sf = -sf;
    end
    p  = PROD_W'(v) * PROD_W'(sf);
    sh = p >>> frac;
    if ((&sh[PROD_W-1:DATA_W-1]) || !(|sh[PROD_W-1:DATA_W-1])) begin
      r = sh[DATA_W-1:0];
    end else if (sh[PROD_W-1]) begin
      r = Q_MIN;
    end else begin
      r = Q_MAX;
    end
    return r;
  endfunction

endpackage

[src/bbpc_in_if.sv]
// ----------------------------------------------------------------------------
// bbpc_in_if
// particle input channel: valid, ready and position/velocity word
// ----------------------------------------------------------------------------
interface bbpc_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  pos_x;
  logic signed [31:0]  pos_y;
  logic signed [31:0]  pos_z;
  logic signed [31:0]  vel_x;
  logic signed [31:0]  vel_y;
  logic signed [31:0]  vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  output ready);
endinterface

[src/bbpc_out_if.sv]
// ----------------------------------------------------------------------------
// bbpc_out_if
// result channel: valid, ready and corrected particle word
// ----------------------------------------------------------------------------
interface bbpc_out_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  new_pos_x;
  logic signed [31:0]  new_pos_y;
  logic signed [31:0]  new_pos_z;
  logic signed [31:0]  new_vel_x;
  logic signed [31:0]  new_vel_y;
  logic signed [31:0]  new_vel_z;
  logic [2:0]          hit_mask;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, hit_mask, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x,
                  new_vel_y, new_vel_z, hit_mask, output ready);
endinterface

[src/bbpc_cfg_if.sv]
// ----------------------------------------------------------------------------
// bbpc_cfg_if
// register write channel: valid, ready, register index and write data
// ----------------------------------------------------------------------------
interface bbpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/bbpc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bbpc_cfg_regs
// box faces and restitution factors, written through the config channel
// ----------------------------------------------------------------------------
module bbpc_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  bbpc_cfg_if.sink           cfg_w,
  output bbpc_pkg::box_cfg_t box
);
  import bbpc_pkg::*;

  box_cfg_t box_r;
  box_cfg_t box_nxt;
  cfg_reg_e idx;

  assign cfg_w.ready = 1'b1;
  assign idx         = cfg_reg_e'(cfg_w.index);
  assign box         = box_r;

  always_comb begin
    box_nxt = box_r;
    if (cfg_w.valid) begin
      case (idx)
        CFG_BOX_MIN_X:    box_nxt.lo[0] = cfg_w.data;
        CFG_BOX_MIN_Y:    box_nxt.lo[1] = cfg_w.data;
        CFG_BOX_MIN_Z:    box_nxt.lo[2] = cfg_w.data;
        CFG_BOX_MAX_X:    box_nxt.hi[0] = cfg_w.data;
        CFG_BOX_MAX_Y:    box_nxt.hi[1] = cfg_w.data;
        CFG_BOX_MAX_Z:    box_nxt.hi[2] = cfg_w.data;
        CFG_NORMAL_FACT:  box_nxt.nf    = cfg_w.data[FACT_W-1:0];
        CFG_TANGENT_FACT: box_nxt.tf    = cfg_w.data[FACT_W-1:0];
        default:          box_nxt       = box_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.lo <= {AXES{BOX_MIN_RST}};
      box_r.hi <= {AXES{BOX_MAX_RST}};
      box_r.nf <= NORM_FAC_RST;
      box_r.tf <= TAN_FAC_RST;
    end else begin
      box_r <= box_nxt;
    end
  end

endmodule

[src/bbpc_cell.sv]
// ----------------------------------------------------------------------------
// bbpc_cell
// one axis of the clamp chain: face compare stage, then three lane scalers
// ----------------------------------------------------------------------------
module bbpc_cell #(
  parameter int unsigned AXIS      = 0,
  parameter int unsigned FRAC_BITS = bbpc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  bbpc_pkg::particle_t in_item,
  input  bbpc_pkg::box_cfg_t  box,
  output logic                out_valid,
  output bbpc_pkg::particle_t out_item
);
  import bbpc_pkg::*;

  logic      a_valid_r;
  particle_t a_item_r;
  particle_t a_item_nxt;
  scale_e    a_mode_r   [AXES];
  scale_e    a_mode_nxt [AXES];
  logic      b_valid_r;
  particle_t b_item_r;
  particle_t b_item_nxt;

  q_t   lo;
  q_t   hi;
  q_t   p;
  q_t   v;
  logic below;
  logic above;

  assign lo    = box.lo[AXIS];
  assign hi    = box.hi[AXIS];
  assign p     = in_item.pos[AXIS];
  assign v     = in_item.vel[AXIS];
  assign below = $signed(p) < $signed(lo);
  assign above = $signed(p) > $signed(hi);

  // face compare and lane selection
  always_comb begin
    a_item_nxt = in_item;
    for (int k = 0; k < AXES; k++) begin
      a_mode_nxt[k] = SC_NONE;
    end
    if (below || above) begin
      a_item_nxt.pos[AXIS] = below ? lo : hi;
      a_item_nxt.hits[AXIS] = 1'b1;
      for (int k = 0; k < AXES; k++) begin
        if (k != AXIS) begin
          a_mode_nxt[k] = SC_TANGENT;
        end
      end
      if ((below && $signed(v) < 0) || (!below && $signed(v) > 0)) begin
        a_mode_nxt[AXIS] = SC_NORMAL;
      end
    end
  end

  // lane scalers
  always_comb begin
    b_item_nxt = a_item_r;
    for (int k = 0; k < AXES; k++) begin
      case (a_mode_r[k])
        SC_NORMAL:  b_item_nxt.vel[k] = scale_sat(a_item_r.vel[k], box.nf, 1'b1,
                                                  FRAC_BITS);
        SC_TANGENT: b_item_nxt.vel[k] = scale_sat(a_item_r.vel[k], box.tf, 1'b0,
                                                  FRAC_BITS);
        default:    b_item_nxt.vel[k] = a_item_r.vel[k];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= a_item_nxt;
      for (int k = 0; k < AXES; k++) begin
        a_mode_r[k] <= a_mode_nxt[k];
      end
      b_item_r <= b_item_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_item  = b_item_r;

endmodule

[src/box_boundary_particle_clamp_core.sv]
// ----------------------------------------------------------------------------
// box_boundary_particle_clamp_core
// clamps a particle against an axis-aligned box, axis by axis, with
// restitution on the normal and scaling on the tangential velocity
//
//   port    dir  role
//   in_s    in   particle word: pos_x..z, vel_x..z
//   out_s   out  result word: new_pos_x..z, new_vel_x..z, hit_mask
//   cfg_w   in   register write: index, data
//
// one word per cycle while no result is held: three axis cells of two stages each
// the last cell stage is the output register; a held result stalls the chain
// in_s.ready is low only while a result waits and out_s.ready is low
// reset clears valid state and loads the default box and factors
// ----------------------------------------------------------------------------
module box_boundary_particle_clamp_core #(
  parameter int unsigned FRAC_BITS = bbpc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bbpc_in_if.sink     in_s,
  bbpc_out_if.source  out_s,
  bbpc_cfg_if.sink    cfg_w
);
  import bbpc_pkg::*;

  box_cfg_t  box;
  logic      en;
  logic      vld  [AXES+1];
  particle_t item [AXES+1];

  bbpc_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_w (cfg_w),
    .box   (box)
  );

  assign en         = out_s.ready || !out_s.valid;
  assign in_s.ready = en;

  assign vld[0]              = in_s.valid;
  assign item[0].pos[0]      = in_s.pos_x;
  assign item[0].pos[1]      = in_s.pos_y;
  assign item[0].pos[2]      = in_s.pos_z;
  assign item[0].vel[0]      = in_s.vel_x;
  assign item[0].vel[1]      = in_s.vel_y;
  assign item[0].vel[2]      = in_s.vel_z;
  assign item[0].hits        = '0;

  for (genvar a = 0; a < AXES; a++) begin : g_cell
    bbpc_cell #(
      .AXIS      (a),
      .FRAC_BITS (FRAC_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (vld[a]),
      .in_item   (item[a]),
      .box       (box),
      .out_valid (vld[a+1]),
      .out_item  (item[a+1])
    );
  end

  assign out_s.valid     = vld[AXES];
  assign out_s.new_pos_x = item[AXES].pos[0];
  assign out_s.new_pos_y = item[AXES].pos[1];
  assign out_s.new_pos_z = item[AXES].pos[2];
  assign out_s.new_vel_x = item[AXES].vel[0];
  assign out_s.new_vel_y = item[AXES].vel[1];
  assign out_s.new_vel_z = item[AXES].vel[2];
  assign out_s.hit_mask  = item[AXES].hits;

  a_stall_only_on_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_s.ready |-> (out_s.valid && !out_s.ready))
    else $error("input stalled without a held result");

  a_chain_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vld[1]) && $stable(vld[2]) && $stable(vld[3])))
    else $error("cell valid moved during stall");

  a_clamp_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && !out_s.hit_mask[0] && $stable(box)) |->
      ($signed(out_s.new_pos_x) >= $signed(box.lo[0]) &&
       $signed(out_s.new_pos_x) <= $signed(box.hi[0])))
    else $error("unclamped x outside box");

endmodule

[sim/tb_box_boundary_particle_clamp_core.sv]
// ----------------------------------------------------------------------------
// tb_box_boundary_particle_clamp_core
// self-checking bench for the box boundary clamp: a queue-fed driver offers
// particle words, a behavioral clamp computes the corrected word for each
// accepted one, and a monitor compares every result word field by field.
// runs a short directed set, then random phases with different boxes and
// factors, sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_box_boundary_particle_clamp_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bbpc_pkg::*;

  localparam int FRAC           = FRAC_BITS_DEF;
  localparam int LATENCY        = 6;
  localparam int HOLD_CYC       = 300;
  localparam int WDOG_LIMIT     = 5000;
  localparam int MAX_REPORTS    = 40;
  localparam int RAND_PER_PHASE = 96;

  typedef struct packed {
    q_t    px, py, pz;
    q_t    vx, vy, vz;
    hits_t hits;
  } pcl_t;

  logic clk;
  logic rst_n;

  bbpc_in_if  in_if ();
  bbpc_out_if out_if ();
  bbpc_cfg_if cfg_if ();

  box_boundary_particle_clamp_core u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_if),
    .out_s (out_if),
    .cfg_w (cfg_if)
  );

  // register copy of the behavioral clamp
  q_t   box_lo [3];
  q_t   box_hi [3];
  fac_t nf;
  fac_t tf;

  pcl_t particle_q [$];
  pcl_t clamp_q [$];
  pcl_t cur_word;

  int src_pct;
  int snk_pct;
  bit hold_on;
  int hold_cnt;
  int n_pushed;
  int n_accepted;
  int n_err;
  int idle_cnt;

  always #10 clk = ~clk;

  // value times factor, optional negation, floor shift, saturate
  function automatic q_t mul_sat(q_t v, fac_t f, bit neg);
    longint p;
    p = longint'(v) * longint'({46'd0, f});
    if (neg) begin
      p = -p;
    end
    p = p >>> FRAC;
    if (p > longint'(Q_MAX)) begin
      p = longint'(Q_MAX);
    end else if (p < longint'(Q_MIN)) begin
      p = longint'(Q_MIN);
    end
    return q_t'(p);
  endfunction

  function automatic pcl_t clamp_particle(pcl_t w);
    q_t    p [3];
    q_t    v [3];
    hits_t h;
    bit    hit;
    pcl_t  r;
    p[0] = w.px; p[1] = w.py; p[2] = w.pz;
    v[0] = w.vx; v[1] = w.vy; v[2] = w.vz;
    h = '0;
    for (int a = 0; a < 3; a++) begin
      hit = 1'b0;
      if (p[a] < box_lo[a]) begin
        p[a] = box_lo[a];
        hit = 1'b1;
        if (v[a] < 0) v[a] = mul_sat(v[a], nf, 1'b1);
      end else if (p[a] > box_hi[a]) begin
        p[a] = box_hi[a];
        hit = 1'b1;
        if (v[a] > 0) v[a] = mul_sat(v[a], nf, 1'b1);
      end
      if (hit) begin
        h[a] = 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (k != a) v[k] = mul_sat(v[k], tf, 1'b0);
        end
      end
    end
    r.px = p[0]; r.py = p[1]; r.pz = p[2];
    r.vx = v[0]; r.vy = v[1]; r.vz = v[2];
    r.hits = h;
    return r;
  endfunction

  // coordinate biased toward the faces and just outside them
  function automatic q_t rand_coord(q_t lo, q_t hi);
    longint t;
    longint span;
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(9))
      0: t = longint'(q_t'($urandom));
      1: t = longint'(lo);
      2: t = longint'(hi);
      3, 4: t = longint'(lo) - longint'($urandom_range(1, 1 << 20));
      5, 6: t = longint'(hi) + longint'($urandom_range(1, 1 << 20));
      default: begin
        if (span < 0) begin
          t = longint'(lo);
        end else begin
          t = longint'(lo) +
              longint'({$urandom, $urandom} & 64'h7fff_ffff_ffff_ffff) % (span + 1);
        end
      end
    endcase
    if (t > longint'(Q_MAX)) t = longint'(Q_MAX);
    if (t < longint'(Q_MIN)) t = longint'(Q_MIN);
    return q_t'(t);
  endfunction

  function automatic q_t rand_vel();
    q_t t;
    case ($urandom_range(7))
      0: t = q_t'($urandom);
      1: t = $urandom_range(1) ? Q_MAX : Q_MIN;
      default: begin
        t = q_t'($urandom_range(0, 1 << 22));
        if ($urandom_range(1)) t = -t;
      end
    endcase
    return t;
  endfunction

  task automatic push_word(q_t px, q_t py, q_t pz, q_t vx, q_t vy, q_t vz);
    pcl_t w;
    w.px = px; w.py = py; w.pz = pz;
    w.vx = vx; w.vy = vy; w.vz = vz;
    w.hits = '0;
    particle_q.push_back(w);
    n_pushed++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_BOX_MIN_X:    box_lo[0] = q_t'(data);
      CFG_BOX_MIN_Y:    box_lo[1] = q_t'(data);
      CFG_BOX_MIN_Z:    box_lo[2] = q_t'(data);
      CFG_BOX_MAX_X:    box_hi[0] = q_t'(data);
      CFG_BOX_MAX_Y:    box_hi[1] = q_t'(data);
      CFG_BOX_MAX_Z:    box_hi[2] = q_t'(data);
      CFG_NORMAL_FACT:  nf = data[FACT_W-1:0];
      CFG_TANGENT_FACT: tf = data[FACT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_box(input q_t lx, ly, lz, hx, hy, hz,
                          input logic [31:0] nfw, tfw);
    write_reg(CFG_BOX_MIN_X, lx);
    write_reg(CFG_BOX_MIN_Y, ly);
    write_reg(CFG_BOX_MIN_Z, lz);
    write_reg(CFG_BOX_MAX_X, hx);
    write_reg(CFG_BOX_MAX_Y, hy);
    write_reg(CFG_BOX_MAX_Z, hz);
    write_reg(CFG_NORMAL_FACT, nfw);
    write_reg(CFG_TANGENT_FACT, tfw);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || clamp_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic run_random(int n, int sp, int kp);
    src_pct = sp;
    snk_pct = kp;
    repeat (n) begin
      push_word(rand_coord(box_lo[0], box_hi[0]), rand_coord(box_lo[1], box_hi[1]),
                rand_coord(box_lo[2], box_hi[2]), rand_vel(), rand_vel(), rand_vel());
    end
    wait_idle();
  endtask

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      n_err++;
      if (n_err <= MAX_REPORTS) begin
        $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
      end
    end
  endtask

  // driver: present queued words, predict on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        clamp_q.push_back(clamp_particle(cur_word));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (particle_q.size() != 0 && $urandom_range(99) >= src_pct) begin
          cur_word = particle_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.pos_x <= cur_word.px;
          in_if.pos_y <= cur_word.py;
          in_if.pos_z <= cur_word.pz;
          in_if.vel_x <= cur_word.vx;
          in_if.vel_y <= cur_word.vy;
          in_if.vel_z <= cur_word.vz;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare result words, drive ready
  always @(posedge clk) begin
    pcl_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (clamp_q.size() == 0) begin
          n_err++;
          $display("%0t unexpected result word", $time);
        end else begin
          want = clamp_q.pop_front();
          cmp_field("new_pos_x", want.px, out_if.new_pos_x);
          cmp_field("new_pos_y", want.py, out_if.new_pos_y);
          cmp_field("new_pos_z", want.pz, out_if.new_pos_z);
          cmp_field("new_vel_x", want.vx, out_if.new_vel_x);
          cmp_field("new_vel_y", want.vy, out_if.new_vel_y);
          cmp_field("new_vel_z", want.vz, out_if.new_vel_z);
          cmp_field("hit_mask", 32'(want.hits), 32'(out_if.hit_mask));
        end
      end
      if (hold_on && hold_cnt < HOLD_CYC) begin
        out_if.ready <= 1'b0;
        hold_cnt <= hold_cnt + 1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        idle_cnt <= 0;
      end else if (idle_cnt >= WDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cnt <= idle_cnt + 1;
      end
    end
  end

  initial begin
    q_t lo_r [3];
    q_t hi_r [3];
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.pos_x = '0; in_if.pos_y = '0; in_if.pos_z = '0;
    in_if.vel_x = '0; in_if.vel_y = '0; in_if.vel_z = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_BOX_MIN_X;
    cfg_if.data = '0;
    for (int a = 0; a < 3; a++) begin
      box_lo[a] = BOX_MIN_RST;
      box_hi[a] = BOX_MAX_RST;
    end
    nf = NORM_FAC_RST;
    tf = TAN_FAC_RST;
    src_pct = 0;
    snk_pct = 0;
    hold_on = 1'b0;
    hold_cnt = 0;
    n_pushed = 0;
    n_accepted = 0;
    n_err = 0;
    idle_cnt = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset box and factors
    push_word(32'sh8000, 32'sh8000, 32'sh8000, 100, -100, 0);
    push_word(0, 65536, 0, -5, 5, -5);
    push_word(-1, 32'sh8000, 32'sh8000, -65536, 32'sh12345, -32'sh777);
    push_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    push_word(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    push_word(32'sh20000, 32'sh8000, 32'sh8000, -65536, 65536, 1);
    wait_idle();

    // flat y and z slabs, factors at and above range, junk above the factor bits
    load_box(-131072, 0, -65536, 131072, 0, -65536, 32'hfffe_0000, 32'h0003_ffff);
    push_word(Q_MAX, 0, -65536, Q_MAX, Q_MIN, -1);
    push_word(Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MAX);
    push_word(0, 0, -65536, 0, 0, 0);
    push_word(-131073, 1, 0, -3, 7, -65536);
    push_word(131073, -1, -65537, 32'sh12345678, -32'sh12345678, 32'sh7ffe0000);
    push_word(-1, -1, -1, -1, -1, -1);
    push_word(1, 1, 1, 1, 1, 1);
    push_word(q_t'(32'h5555_5555), q_t'(32'haaaa_aaaa), q_t'(32'h5555_5555),
              q_t'(32'haaaa_aaaa), q_t'(32'h5555_5555), q_t'(32'haaaa_aaaa));
    push_word(q_t'(32'haaaa_aaaa), q_t'(32'h5555_5555), q_t'(32'haaaa_aaaa),
              q_t'(32'h5555_5555), q_t'(32'haaaa_aaaa), q_t'(32'h5555_5555));
    wait_idle();

    load_box(-262144, -262144, -262144, 262144, 262144, 262144, 49152, 32768);
    run_random(RAND_PER_PHASE, 0, 0);

    load_box(-65536, 0, -6553600, 196608, 0, -3276800, 131072, 65536);
    run_random(RAND_PER_PHASE, 65, 0);

    // full range x, inverted y, half range z
    load_box(Q_MIN, 327680, Q_MIN, Q_MAX, -327680, 0,
             {14'($urandom_range(0, 16383)), 18'h3ffff}, 32'h0003_ffff);
    run_random(RAND_PER_PHASE, 0, 65);

    for (int a = 0; a < 3; a++) begin
      lo_r[a] = q_t'($urandom_range(0, 1 << 25)) - q_t'(1 << 24);
      hi_r[a] = lo_r[a] + q_t'($urandom_range(0, 1 << 22));
    end
    load_box(lo_r[0], lo_r[1], lo_r[2], hi_r[0], hi_r[1], hi_r[2],
             $urandom_range(0, 131072), $urandom_range(0, 131072));
    run_random(RAND_PER_PHASE, 24, 24);

    // long receiver hold-off while the sender keeps offering
    load_box(-65536, -65536, -65536, 65536, 65536, 65536, 0, 0);
    hold_on = 1'b1;
    run_random(RAND_PER_PHASE, 0, 0);
    hold_on = 1'b0;

    wait_idle();
    if (n_err == 0 && clamp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[sim.f]
src/bbpc_pkg.sv
src/bbpc_in_if.sv
src/bbpc_out_if.sv
src/bbpc_cfg_if.sv
src/bbpc_cfg_regs.sv
src/bbpc_cell.sv
src/box_boundary_particle_clamp_core.sv
sim/tb_box_boundary_particle_clamp_core.sv
